@@ rtl/assert_macros.svh @@
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/vbm_pkg.sv @@
package vbm_pkg;
	localparam int BANK_TOTAL = 9;
	localparam int STORE_BYTES = 671744;
	localparam int ADDR_W = 20;
	localparam logic [31:0] TRANSFER_WINDOW_BASE = 32'd109051904;
	localparam logic [7:0] ENABLE_BIT = 8'h80;

	typedef enum logic [2:0] {
		OP_WR_CTRL = 3'd0,
		OP_RD_CTRL = 3'd1,
		OP_XFER_RD = 3'd2,
		OP_XFER_WR = 3'd3,
		OP_WIN_RD  = 3'd4
	} op_t;

	localparam logic [3:0] TGT_TRANSFER = 4'd0;
	localparam logic [3:0] TGT_BG_MAIN = 4'd1;
	localparam logic [3:0] TGT_OBJ_MAIN = 4'd2;
	localparam logic [3:0] TGT_TEXTURE = 4'd3;
	localparam logic [3:0] TGT_CPU2 = 4'd4;
	localparam logic [3:0] TGT_BG_SUB = 4'd5;
	localparam logic [3:0] TGT_OBJ_SUB = 4'd6;
	localparam logic [3:0] TGT_TEX_PAL = 4'd7;
	localparam logic [3:0] TGT_BGPAL_MAIN = 4'd8;
	localparam logic [3:0] TGT_OBJPAL_MAIN = 4'd9;
	localparam logic [3:0] TGT_BGPAL_SUB = 4'd10;
	localparam logic [3:0] TGT_OBJPAL_SUB = 4'd11;
	localparam logic [3:0] TGT_RESERVED = 4'd12;

	typedef struct packed {
		logic [2:0]  operation;
		logic [3:0]  bank_number;
		logic [7:0]  control_byte;
		logic [31:0] transfer_address;
		logic [3:0]  window_target;
		logic [31:0] window_offset;
		logic [7:0]  write_byte;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]  read_byte;
		logic        hit;
		logic [31:0] overlap_total;
		logic [31:0] unbacked_total;
	} out_beat_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture input, decode
		logic mem_go;   // drive memory / control access
		logic finish;   // form result
		logic clr_en;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
	} dp_sts_t;

	function automatic logic [31:0] bank_size(input logic [3:0] k);
		case (k)
			4'd0, 4'd1, 4'd2, 4'd3: bank_size = 32'h20000;
			4'd4: bank_size = 32'h10000;
			4'd7: bank_size = 32'h8000;
			default: bank_size = 32'h4000;
		endcase
	endfunction

	function automatic logic [31:0] bank_start(input logic [3:0] k);
		case (k)
			4'd0: bank_start = 32'h00000;
			4'd1: bank_start = 32'h20000;
			4'd2: bank_start = 32'h40000;
			4'd3: bank_start = 32'h60000;
			4'd4: bank_start = 32'h80000;
			4'd5: bank_start = 32'h90000;
			4'd6: bank_start = 32'h94000;
			4'd7: bank_start = 32'h98000;
			default: bank_start = 32'hA0000;
		endcase
	endfunction

	function automatic logic [31:0] small_offset(input logic [1:0] sel);
		small_offset = (sel[0] ? 32'h4000 : 32'h0) + (sel[1] ? 32'h10000 : 32'h0);
	endfunction

	// returns {target, base}
	function automatic logic [35:0] decode(input logic [3:0] k, input logic [7:0] v);
		logic [2:0]  mode;
		logic [1:0]  sel;
		logic [3:0]  t;
		logic [31:0] b;
		mode = v[2:0];
		sel = v[4:3];
		t = TGT_RESERVED;
		b = '0;
		case (k)
			4'd0, 4'd1: begin
				case (mode[1:0])
					2'd0: t = TGT_TRANSFER;
					2'd1: begin t = TGT_BG_MAIN; b = {13'd0, sel, 17'd0}; end
					2'd2: begin t = TGT_OBJ_MAIN; b = {14'd0, sel[0], 17'd0}; end
					default: begin t = TGT_TEXTURE; b = {13'd0, sel, 17'd0}; end
				endcase
			end
			4'd2, 4'd3: begin
				case (mode)
					3'd0: t = TGT_TRANSFER;
					3'd1: begin t = TGT_BG_MAIN; b = {13'd0, sel, 17'd0}; end
					3'd2: begin t = TGT_CPU2; b = {14'd0, sel[0], 17'd0}; end
					3'd3: begin t = TGT_TEXTURE; b = {13'd0, sel, 17'd0}; end
					3'd4: t = (k == 4'd2) ? TGT_BG_SUB : TGT_OBJ_SUB;
					default: t = TGT_RESERVED;
				endcase
			end
			4'd4: begin
				case (mode)
					3'd0: t = TGT_TRANSFER;
					3'd1: t = TGT_BG_MAIN;
					3'd2: t = TGT_OBJ_MAIN;
					3'd3: t = TGT_TEX_PAL;
					3'd4: t = TGT_BGPAL_MAIN;
					default: t = TGT_RESERVED;
				endcase
			end
			4'd5, 4'd6: begin
				case (mode)
					3'd0: t = TGT_TRANSFER;
					3'd1: begin t = TGT_BG_MAIN; b = small_offset(sel); end
					3'd2: begin t = TGT_OBJ_MAIN; b = small_offset(sel); end
					3'd3: begin t = TGT_TEX_PAL; b = small_offset(sel); end
					3'd4: t = TGT_BGPAL_MAIN;
					3'd5: t = TGT_OBJPAL_MAIN;
					default: t = TGT_RESERVED;
				endcase
			end
			4'd7: begin
				case (mode[1:0])
					2'd0: t = TGT_TRANSFER;
					2'd1: t = TGT_BG_SUB;
					2'd2: t = TGT_BGPAL_SUB;
					default: t = TGT_RESERVED;
				endcase
			end
			default: begin
				case (mode[1:0])
					2'd0: t = TGT_TRANSFER;
					2'd1: begin t = TGT_BG_SUB; b = 32'h8000; end
					2'd2: t = TGT_OBJ_SUB;
					default: t = TGT_OBJPAL_SUB;
				endcase
			end
		endcase
		decode = {t, b};
	endfunction
endpackage

@@ rtl/vbm_ram.sv @@
module vbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ rtl/vbm_datapath.sv @@
`include "assert_macros.svh"
module vbm_datapath
	import vbm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_beat_t  in_data,
	input  dp_cmd_t   cmd,
	output dp_sts_t   sts,
	output out_beat_t result
);
	in_beat_t                it_s1;
	logic [7:0]              ctrl_q [BANK_TOTAL];
	logic [31:0]             ovl_q;
	logic [31:0]             unb_q;
	logic                    found_s1;
	logic [3:0]              extra_s1;
	logic [ADDR_W-1:0]       clr_addr_q;
	logic                    clr_last_q;
	logic                    mem_we;
	logic [ADDR_W-1:0]       mem_addr;
	logic [7:0]              mem_wdata;
	logic [7:0]              mem_rdata;
	logic                    x_found;
	logic [ADDR_W-1:0]       x_pos;
	logic                    w_found;
	logic [ADDR_W-1:0]       w_pos;
	logic [3:0]              w_extra;
	logic [32:0]             ovl_sum;
	logic [31:0]             ovl_next;
	logic [7:0]              res_byte;
	logic                    res_hit;

	// transfer lookup: first covering bank decides
	always_comb begin
		logic        done;
		logic [31:0] base;
		logic [31:0] diff;
		logic [35:0] dec;
		logic [31:0] p;
		done = 1'b0;
		x_found = 1'b0;
		x_pos = '0;
		for (int k = 0; k < BANK_TOTAL; k++) begin
			base = TRANSFER_WINDOW_BASE + bank_start(4'(k));
			diff = it_s1.transfer_address - base;
			dec = decode(4'(k), ctrl_q[k]);
			p = bank_start(4'(k)) + diff;
			if (!done && it_s1.transfer_address >= base
					&& it_s1.transfer_address < base + bank_size(4'(k))) begin
				done = 1'b1;
				x_found = ctrl_q[k][7] && dec[35:32] == TGT_TRANSFER
					&& p < 32'(STORE_BYTES);
				x_pos = p[ADDR_W-1:0];
			end
		end
	end

	// window match across the nine banks
	always_comb begin
		logic [35:0] dec;
		logic [31:0] inner;
		logic [31:0] p;
		w_found = 1'b0;
		w_pos = '0;
		w_extra = '0;
		for (int k = 0; k < BANK_TOTAL; k++) begin
			dec = decode(4'(k), ctrl_q[k]);
			inner = it_s1.window_offset - dec[31:0];
			p = bank_start(4'(k)) + inner;
			if (ctrl_q[k][7] && dec[35:32] == it_s1.window_target
					&& inner < bank_size(4'(k))) begin
				if (w_found) begin
					w_extra = w_extra + 4'd1;
				end else begin
					w_found = 1'b1;
					w_pos = p[ADDR_W-1:0];
				end
			end
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_addr = it_s1.operation == OP_XFER_RD || it_s1.operation == OP_XFER_WR
			? x_pos : w_pos;
		mem_wdata = it_s1.write_byte;
		if (cmd.clr_en) begin
			mem_we = 1'b1;
			mem_addr = clr_addr_q;
			mem_wdata = '0;
		end else if (cmd.mem_go && it_s1.operation == OP_XFER_WR && x_found) begin
			mem_we = 1'b1;
		end
	end

	vbm_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			it_s1 <= in_data;
		end
		if (cmd.mem_go) begin
			found_s1 <= (it_s1.operation == OP_XFER_RD || it_s1.operation == OP_XFER_WR)
				? x_found : w_found;
			extra_s1 <= w_extra;
		end
	end

	assign ovl_sum = {1'b0, ovl_q} + {29'd0, extra_s1};
	assign ovl_next = ovl_sum[32] ? 32'hFFFF_FFFF : ovl_sum[31:0];

	always_comb begin
		res_byte = '0;
		res_hit = 1'b0;
		case (it_s1.operation)
			OP_WR_CTRL: res_hit = it_s1.bank_number < 4'(BANK_TOTAL);
			OP_RD_CTRL: begin
				if (it_s1.bank_number < 4'(BANK_TOTAL)) begin
					res_byte = ctrl_q[it_s1.bank_number];
					res_hit = 1'b1;
				end
			end
			OP_XFER_RD: begin
				res_hit = found_s1;
				res_byte = found_s1 ? mem_rdata : 8'd0;
			end
			OP_XFER_WR: res_hit = found_s1;
			OP_WIN_RD: begin
				res_hit = found_s1;
				res_byte = found_s1 ? mem_rdata : 8'd0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < BANK_TOTAL; k++) begin
				ctrl_q[k] <= '0;
			end
			ovl_q <= '0;
			unb_q <= '0;
			result <= '0;
			clr_addr_q <= '0;
			clr_last_q <= 1'b0;
		end else begin
			if (cmd.clr_en) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				clr_last_q <= clr_addr_q == ADDR_W'(STORE_BYTES - 1);
			end
			if (cmd.mem_go && it_s1.operation == OP_WR_CTRL
					&& it_s1.bank_number < 4'(BANK_TOTAL)) begin
				ctrl_q[it_s1.bank_number] <= it_s1.control_byte;
			end
			if (cmd.finish) begin
				result.read_byte <= res_byte;
				result.hit <= res_hit;
				if (it_s1.operation == OP_WIN_RD) begin
					ovl_q <= ovl_next;
					result.overlap_total <= ovl_next;
					if (!found_s1 && unb_q != 32'hFFFF_FFFF) begin
						unb_q <= unb_q + 32'd1;
						result.unbacked_total <= unb_q + 32'd1;
					end else begin
						result.unbacked_total <= unb_q;
					end
				end else begin
					result.overlap_total <= ovl_q;
					result.unbacked_total <= unb_q;
				end
			end
		end
	end

	assign sts.clr_done = clr_last_q;

	`ASSERT_IMPL(a_ovl_mono, clk, arst_n, cmd.finish |=> ovl_q >= $past(ovl_q))
	`ASSERT_IMPL(a_unb_mono, clk, arst_n, cmd.finish |=> unb_q >= $past(unb_q))
	`ASSERT_IMPL(a_no_wr_clr, clk, arst_n, cmd.clr_en |-> !cmd.mem_go)
endmodule

@@ rtl/vbm_ctrl.sv @@
`include "assert_macros.svh"
module vbm_ctrl
	import vbm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_RESULT,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_stall = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.clr_en = state_q == ST_CLEAR && !sts.clr_done;
		cmd.load = state_q == ST_IDLE && in_valid;
		cmd.mem_go = state_q == ST_ACCESS;
		cmd.finish = state_q == ST_RESULT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: if (sts.clr_done) state_q <= ST_IDLE;
				ST_IDLE: if (in_valid) state_q <= ST_ACCESS;
				ST_ACCESS: state_q <= ST_RESULT;
				ST_RESULT: begin
					state_q <= ST_DONE;
					out_valid_q <= 1'b1;
				end
				ST_DONE: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_ov_done, clk, arst_n, out_valid_q |-> state_q == ST_DONE)
	`ASSERT_IMPL(a_load_idle, clk, arst_n, cmd.load |=> state_q == ST_ACCESS)
	`ASSERT_IMPL(a_finish, clk, arst_n, cmd.finish |=> out_valid_q)
endmodule

@@ rtl/video_bank_mapper_top.sv @@
// Nine-bank video memory mapper.
// Input channel: in_valid/in_stall with in_data (operation, bank, control
// byte, transfer address, window target/offset, write byte). Output channel:
// out_valid/out_stall with out_data (read byte, hit, two saturating counters).
// One result beat per input beat.
// Timing: after the input beat is accepted, decode plus store access (ACCESS
// state) and then the result register (RESULT state) come before out_valid
// rises. One item is in flight at a time; the next input is taken the cycle
// after the result beat leaves. The single-port byte store and its
// registered read set this.
// Reset: control bytes and counters clear at once; the byte store is then
// zeroed one byte a cycle, all 671744 bytes, while in_stall stays high.
// Receiver stall: out_data holds and in_stall stays high until the result is
// taken.
module video_bank_mapper_top
	import vbm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	vbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	vbm_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (in_data),
		.cmd     (cmd),
		.sts     (sts),
		.result  (out_data)
	);
endmodule

@@ bench/testbench.sv @@
module testbench;
	import vbm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_ITEMS = 1030;
	localparam int IDLE_LIMIT = 2000000;
	localparam logic [31:0] SIZE_OF [9] = '{32'h20000, 32'h20000, 32'h20000, 32'h20000,
		32'h10000, 32'h4000, 32'h4000, 32'h8000, 32'h4000};
	localparam logic [31:0] START_OF [9] = '{32'h00000, 32'h20000, 32'h40000, 32'h60000,
		32'h80000, 32'h90000, 32'h94000, 32'h98000, 32'hA0000};

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_beat_t out_data;

	video_bank_mapper_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// mapper state mirror
	logic [7:0]  vram [int];
	logic [7:0]  ctrl_regs [9];
	logic [31:0] overlap_cnt;
	logic [31:0] unbacked_cnt;

	out_beat_t   pending_results [$];
	int          errors;
	int          send_idle_pct;
	int          recv_stall_pct;
	bit          hold_req;
	int          quiet_cycles;

	typedef struct {
		in_beat_t  beat;
		bit        typed;
		out_beat_t result;
	} stim_row_t;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void bank_map(input int k, input logic [7:0] v,
		output logic [3:0] tgt, output logic [31:0] base);
		logic [2:0]  m;
		logic [1:0]  s;
		logic [31:0] sub;
		m = v[2:0];
		s = v[4:3];
		sub = (s[0] ? 32'h4000 : 32'h0) + (s[1] ? 32'h10000 : 32'h0);
		tgt = TGT_RESERVED;
		base = '0;
		if (k <= 1) begin
			case (m[1:0])
				2'd0: tgt = TGT_TRANSFER;
				2'd1: begin tgt = TGT_BG_MAIN; base = 32'h20000 * s; end
				2'd2: begin tgt = TGT_OBJ_MAIN; base = 32'h20000 * s[0]; end
				default: begin tgt = TGT_TEXTURE; base = 32'h20000 * s; end
			endcase
		end else if (k <= 3) begin
			case (m)
				3'd0: tgt = TGT_TRANSFER;
				3'd1: begin tgt = TGT_BG_MAIN; base = 32'h20000 * s; end
				3'd2: begin tgt = TGT_CPU2; base = 32'h20000 * s[0]; end
				3'd3: begin tgt = TGT_TEXTURE; base = 32'h20000 * s; end
				3'd4: tgt = (k == 2) ? TGT_BG_SUB : TGT_OBJ_SUB;
				default: ;
			endcase
		end else if (k == 4) begin
			case (m)
				3'd0: tgt = TGT_TRANSFER;
				3'd1: tgt = TGT_BG_MAIN;
				3'd2: tgt = TGT_OBJ_MAIN;
				3'd3: tgt = TGT_TEX_PAL;
				3'd4: tgt = TGT_BGPAL_MAIN;
				default: ;
			endcase
		end else if (k <= 6) begin
			case (m)
				3'd0: tgt = TGT_TRANSFER;
				3'd1: begin tgt = TGT_BG_MAIN; base = sub; end
				3'd2: begin tgt = TGT_OBJ_MAIN; base = sub; end
				3'd3: begin tgt = TGT_TEX_PAL; base = sub; end
				3'd4: tgt = TGT_BGPAL_MAIN;
				3'd5: tgt = TGT_OBJPAL_MAIN;
				default: ;
			endcase
		end else if (k == 7) begin
			case (m[1:0])
				2'd0: tgt = TGT_TRANSFER;
				2'd1: tgt = TGT_BG_SUB;
				2'd2: tgt = TGT_BGPAL_SUB;
				default: ;
			endcase
		end else begin
			case (m[1:0])
				2'd0: tgt = TGT_TRANSFER;
				2'd1: begin tgt = TGT_BG_SUB; base = 32'h8000; end
				2'd2: tgt = TGT_OBJ_SUB;
				default: tgt = TGT_OBJPAL_SUB;
			endcase
		end
	endfunction

	function automatic bit xfer_find(input logic [31:0] addr, output int pos);
		logic [31:0] lo;
		logic [3:0]  tgt;
		logic [31:0] base;
		pos = 0;
		for (int k = 0; k < 9; k++) begin
			lo = TRANSFER_WINDOW_BASE + START_OF[k];
			if (addr < lo || addr >= lo + SIZE_OF[k])
				continue;
			bank_map(k, ctrl_regs[k], tgt, base);
			if (!ctrl_regs[k][7] || tgt != TGT_TRANSFER)
				return 1'b0;
			pos = START_OF[k] + (addr - lo);
			return pos < STORE_BYTES;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] vram_byte(input int pos);
		return vram.exists(pos) ? vram[pos] : 8'h00;
	endfunction

	function automatic out_beat_t map_access(input in_beat_t b);
		out_beat_t   r;
		int          pos;
		bit          found;
		logic [3:0]  tgt;
		logic [31:0] base;
		logic [31:0] inner;
		r = '0;
		found = 1'b0;
		pos = 0;
		case (b.operation)
			OP_WR_CTRL: if (b.bank_number < 9) begin
				ctrl_regs[b.bank_number] = b.control_byte;
				r.hit = 1'b1;
			end
			OP_RD_CTRL: if (b.bank_number < 9) begin
				r.read_byte = ctrl_regs[b.bank_number];
				r.hit = 1'b1;
			end
			OP_XFER_RD: if (xfer_find(b.transfer_address, pos)) begin
				r.read_byte = vram_byte(pos);
				r.hit = 1'b1;
			end
			OP_XFER_WR: if (xfer_find(b.transfer_address, pos)) begin
				vram[pos] = b.write_byte;
				r.hit = 1'b1;
			end
			OP_WIN_RD: begin
				for (int k = 0; k < 9; k++) begin
					if (!ctrl_regs[k][7])
						continue;
					bank_map(k, ctrl_regs[k], tgt, base);
					inner = b.window_offset - base;
					if (tgt != b.window_target || inner >= SIZE_OF[k])
						continue;
					if (found) begin
						if (overlap_cnt != '1)
							overlap_cnt++;
					end else begin
						found = 1'b1;
						pos = START_OF[k] + inner;
					end
				end
				if (found && pos < STORE_BYTES) begin
					r.read_byte = vram_byte(pos);
					r.hit = 1'b1;
				end else if (unbacked_cnt != '1) begin
					unbacked_cnt++;
				end
			end
			default: ;
		endcase
		r.overlap_total = overlap_cnt;
		r.unbacked_total = unbacked_cnt;
		return r;
	endfunction

	function automatic in_beat_t random_access();
		in_beat_t    b;
		int          r;
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		b = raw[$bits(in_beat_t)-1:0];
		r = $urandom_range(0, 99);
		if (r < 15)
			b.operation = OP_WR_CTRL;
		else if (r < 22)
			b.operation = OP_RD_CTRL;
		else if (r < 42)
			b.operation = OP_XFER_RD;
		else if (r < 62)
			b.operation = OP_XFER_WR;
		else if (r < 95)
			b.operation = OP_WIN_RD;
		else
			b.operation = 3'($urandom_range(5, 7));
		b.bank_number = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(0, 8))
			: 4'($urandom_range(9, 15));
		if ($urandom_range(0, 99) < 75)
			b.control_byte[7] = 1'b1;
		if ($urandom_range(0, 99) < 40)
			b.control_byte[2:0] = 3'd0;
		if ($urandom_range(0, 99) < 85)
			b.transfer_address = TRANSFER_WINDOW_BASE + $urandom_range(0, 32'hA3FFF);
		b.window_target = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(0, 12))
			: 4'($urandom_range(13, 15));
		if ($urandom_range(0, 99) < 85)
			b.window_offset = $urandom_range(0, 32'h7FFFF);
		return b;
	endfunction

	function automatic in_beat_t mk(input op_t op, input logic [3:0] bank,
		input logic [7:0] cb, input logic [31:0] ta, input logic [3:0] wt,
		input logic [31:0] wo, input logic [7:0] wb);
		in_beat_t b;
		b.operation = op;
		b.bank_number = bank;
		b.control_byte = cb;
		b.transfer_address = ta;
		b.window_target = wt;
		b.window_offset = wo;
		b.write_byte = wb;
		return b;
	endfunction

	task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t known);
		out_beat_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do
			@(posedge clk);
		while (in_stall);
		predicted = map_access(b);
		pending_results.push_back(typed ? known : predicted);
		@(negedge clk);
	endtask

	// receiver side
	int hold_left;
	initial begin
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = 300;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		out_beat_t want;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.read_byte !== want.read_byte) begin
					$error("read_byte expected %0h actual %0h", want.read_byte, out_data.read_byte);
					errors++;
				end
				if (out_data.hit !== want.hit) begin
					$error("hit expected %0b actual %0b", want.hit, out_data.hit);
					errors++;
				end
				if (out_data.overlap_total !== want.overlap_total) begin
					$error("overlap_total expected %0d actual %0d",
						want.overlap_total, out_data.overlap_total);
					errors++;
				end
				if (out_data.unbacked_total !== want.unbacked_total) begin
					$error("unbacked_total expected %0d actual %0d",
						want.unbacked_total, out_data.unbacked_total);
					errors++;
				end
			end
		end
	end

	// watchdog covers the post-reset store clear
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("video_bank_mapper_top: mismatch");
			$finish;
		end
	end

	initial begin
		stim_row_t rows [$];
		out_beat_t z;
		logic [31:0] wb;
		int drain;
		z = '0;
		wb = TRANSFER_WINDOW_BASE;
		errors = 0;
		quiet_cycles = 0;
		hold_req = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		overlap_cnt = '0;
		unbacked_cnt = '0;
		foreach (ctrl_regs[i])
			ctrl_regs[i] = '0;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		rows.push_back('{mk(OP_RD_CTRL, 0, 0, 0, 0, 0, 0), 1, '{8'h00, 1'b1, 0, 0}});
		rows.push_back('{mk(OP_RD_CTRL, 15, 0, 0, 0, 0, 0), 1, z});
		rows.push_back('{mk(OP_WR_CTRL, 9, 8'hFF, 0, 0, 0, 0), 1, z});
		rows.push_back('{mk(op_t'(3'd7), 0, 0, 0, 0, 0, 0), 1, z});
		rows.push_back('{mk(OP_WIN_RD, 0, 0, 0, 15, 0, 0), 1, '{8'h00, 1'b0, 0, 1}});
		rows.push_back('{mk(OP_XFER_RD, 0, 0, wb, 0, 0, 0), 1, '{8'h00, 1'b0, 0, 1}});
		rows.push_back('{mk(OP_WR_CTRL, 0, 8'h80, 0, 0, 0, 0), 0, z});
		rows.push_back('{mk(OP_XFER_WR, 0, 0, wb, 0, 0, 8'hA5), 0, z});
		rows.push_back('{mk(OP_XFER_RD, 0, 0, wb, 0, 0, 0), 0, z});
		rows.push_back('{mk(OP_XFER_WR, 0, 0, wb + 32'h1FFFF, 0, 0, 8'h5A), 0, z});
		rows.push_back('{mk(OP_WR_CTRL, 0, 8'h81, 0, 0, 0, 0), 0, z});
		rows.push_back('{mk(OP_WIN_RD, 0, 0, 0, TGT_BG_MAIN, 0, 0), 0, z});
		rows.push_back('{mk(OP_WR_CTRL, 1, 8'h81, 0, 0, 0, 0), 0, z});
		rows.push_back('{mk(OP_WIN_RD, 0, 0, 0, TGT_BG_MAIN, 32'h1FFFF, 0), 0, z});
		rows.push_back('{mk(OP_WR_CTRL, 2, 8'hFF, 0, 0, 0, 0), 0, z});
		rows.push_back('{mk(OP_WIN_RD, 0, 0, 0, TGT_RESERVED, 0, 0), 0, z});
		rows.push_back('{mk(OP_WR_CTRL, 8, 8'h9B, 0, 0, 0, 0), 0, z});
		rows.push_back('{mk(OP_XFER_WR, 0, 0, wb + 32'hA3FFF, 0, 0, 8'h11), 0, z});
		rows.push_back('{mk(OP_WR_CTRL, 8, 8'h80, 0, 0, 0, 0), 0, z});
		rows.push_back('{mk(OP_XFER_WR, 0, 0, wb + 32'hA3FFF, 0, 0, 8'hFF), 0, z});
		rows.push_back('{mk(OP_XFER_RD, 0, 0, wb + 32'hA3FFF, 0, 0, 0), 0, z});
		rows.push_back('{mk(OP_XFER_RD, 0, 0, 32'hFFFFFFFF, 0, 0, 0), 0, z});
		rows.push_back('{mk(OP_WIN_RD, 0, 0, 0, TGT_TRANSFER, 32'hFFFFFFFF, 0), 0, z});
		rows.push_back('{mk(OP_RD_CTRL, 8, 0, 0, 0, 0, 0), 0, z});
		rows.push_back('{mk(op_t'(3'd5), 0, 0, 0, 0, 0, 0), 0, z});

		foreach (rows[i])
			send_beat(rows[i].beat, rows[i].typed, rows[i].result);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			case (n * 5 / RAND_ITEMS)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 68; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 68; end
				3: begin send_idle_pct = 24; recv_stall_pct = 24; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			if (n == RAND_ITEMS * 4 / 5)
				hold_req = 1'b1;
			send_beat(random_access(), 1'b0, z);
		end
		in_valid <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;

		drain = 0;
		while (pending_results.size() != 0 && drain < 100000) begin
			@(posedge clk);
			drain++;
		end
		repeat (10) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("video_bank_mapper_top: match");
		else
			$display("video_bank_mapper_top: mismatch");
		$finish;
	end
endmodule
